>>> hw/rtl/sats_pkg.sv
// ----------------------------------------------------------------------------
// sats_pkg: shared types and constants for the set-associative tag store
// Request and response items, the per-set row layout, coherence state and
// request codes, and small helpers for the LRU order and the reset row.
// ----------------------------------------------------------------------------
package sats_pkg;

	localparam int NUM_LINES = 256;
	localparam int WAYS      = 4;
	localparam int TAG_BITS  = 32;
	localparam int NUM_SETS  = ((NUM_LINES / WAYS) > 0) ? (NUM_LINES / WAYS) : 1;
	localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

	// coherence states
	localparam logic [2:0] ST_INVALID   = 3'd0;
	localparam logic [2:0] ST_SHARED    = 3'd1;
	localparam logic [2:0] ST_EXCLUSIVE = 3'd2;
	localparam logic [2:0] ST_OWNER     = 3'd3;
	localparam logic [2:0] ST_MODIFIED  = 3'd4;

	typedef enum logic [1:0] {
		REQ_LOOKUP    = 2'd0,
		REQ_SET_STATE = 2'd1,
		REQ_TOUCH     = 2'd2,
		REQ_INSERT    = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t     req_type;
		logic [5:0]    set_index;
		logic [31:0]   tag;
		logic [2:0]    new_state;
	} req_t;

	typedef struct packed {
		logic [2:0] line_state;
		logic       hit;
		logic       victim_dirty;
	} rsp_t;

	typedef logic [WAYS-1:0][WAY_BITS-1:0] lru_t;

	// one set: tags, states and the LRU order (entry 0 is LRU)
	typedef struct packed {
		logic [WAYS-1:0][TAG_BITS-1:0] tags;
		logic [WAYS-1:0][2:0]          states;
		lru_t                          order;
	} row_t;

	localparam int ROW_BITS = $bits(row_t);

	function automatic logic is_dirty(input logic [2:0] st);
		return (st == ST_MODIFIED) || (st == ST_OWNER);
	endfunction

	function automatic row_t reset_row();
		row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r.tags[w]   = TAG_BITS'(w);
			r.states[w] = ST_INVALID;
			r.order[w]  = WAY_BITS'(w);
		end
		return r;
	endfunction

	// move a way to the MRU end, closing the gap it leaves
	function automatic lru_t make_mru(input lru_t order, input logic [WAY_BITS-1:0] way);
		lru_t o;
		logic seen;
		o    = order;
		seen = 1'b0;
		for (int i = 0; i < WAYS - 1; i++) begin
			if (order[i] == way) seen = 1'b1;
			if (seen) o[i] = order[i+1];
		end
		if (seen || (order[WAYS-1] == way)) o[WAYS-1] = way;
		return o;
	endfunction

endpackage

>>> hw/rtl/sats_ram.sv
// ----------------------------------------------------------------------------
// sats_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module sats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/set_assoc_tag_store_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_store_lru: 4-way set-associative tag store with true LRU
// Tag, coherence state and LRU order per set; lookup, set state, touch, insert.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: an item (req) is taken on a rising edge with start high
//   and busy low. busy is never raised, so an item can be issued every cycle.
//   Response channel: one item per request on rsp, marked by done for exactly
//   one cycle. The receiver cannot hold results off; none is ever dropped.
//   Response path: the request is held in stage 1 (req_s1) while the RAM row
//   arrives, and the response is registered into rsp_q alongside done.
//   Throughput: one item per cycle.
//   Each set is one RAM row (tags, states, LRU order). The RAM read is issued
//   at the request edge; the row is updated and written back at the next
//   edge. A request to the set written at that same edge is served from a
//   one-deep bypass register, so back-to-back items to one set stay exact.
//   Reset: control and per-set valid bits clear at once; an unwritten set
//   reads as way w holding tag w, invalid, way 0 LRU. No clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_tag_store_lru (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sats_pkg::req_t req,
	output logic          done,
	output sats_pkg::rsp_t rsp
);

	// stage 1: request held while the RAM row arrives
	logic                               vld_s1;
	sats_pkg::req_t                     req_s1;
	logic [sats_pkg::SET_BITS-1:0]      set_s1;

	// set rows ever written since reset
	logic [sats_pkg::NUM_SETS-1:0]      row_vld_q;

	// bypass of the row written at the last edge
	logic                               byp_vld_q;
	logic [sats_pkg::SET_BITS-1:0]      byp_set_q;
	sats_pkg::row_t                     wr_row_q;

	logic [sats_pkg::ROW_BITS-1:0]      rd_data;
	sats_pkg::row_t                     row_cur;
	sats_pkg::row_t                     row_nxt;
	logic [sats_pkg::WAY_BITS-1:0]      victim;
	logic [sats_pkg::WAY_BITS-1:0]      hit_way;
	logic                               hit;
	logic                               dirty;
	logic [2:0]                         prior_state;
	logic [2:0]                         nst;
	logic [sats_pkg::WAYS-1:0]          ord_mask;

	logic                               done_q;
	sats_pkg::rsp_t                     rsp_q;

	logic                               accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign set_s1 = req_s1.set_index[sats_pkg::SET_BITS-1:0];

	sats_ram #(
		.WIDTH (sats_pkg::ROW_BITS),
		.DEPTH (sats_pkg::NUM_SETS)
	) u_rows (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (set_s1),
		.wdata (row_nxt),
		.raddr (req.set_index[sats_pkg::SET_BITS-1:0]),
		.rdata (rd_data)
	);

	// current view of the set: bypass, then RAM, else the reset contents
	always_comb begin
		if (byp_vld_q && (byp_set_q == set_s1)) begin
			row_cur = wr_row_q;
		end else if (row_vld_q[set_s1]) begin
			row_cur = sats_pkg::row_t'(rd_data);
		end else begin
			row_cur = sats_pkg::reset_row();
		end
	end

	// tag compare over all ways in parallel, lowest way wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = sats_pkg::WAYS - 1; w >= 0; w--) begin
			if (row_cur.tags[w] == req_s1.tag[sats_pkg::TAG_BITS-1:0]) begin
				hit     = 1'b1;
				hit_way = sats_pkg::WAY_BITS'(w);
			end
		end
	end

	assign victim      = row_cur.order[0];
	assign dirty       = sats_pkg::is_dirty(row_cur.states[victim]);
	assign prior_state = hit ? row_cur.states[hit_way] : sats_pkg::ST_INVALID;
	// undefined state codes fold to invalid
	assign nst    = (req_s1.new_state > sats_pkg::ST_MODIFIED) ?
	                sats_pkg::ST_INVALID : req_s1.new_state;

	always_comb begin
		row_nxt = row_cur;
		case (req_s1.req_type)
			sats_pkg::REQ_LOOKUP: begin
			end
			sats_pkg::REQ_SET_STATE: begin
				if (hit) row_nxt.states[hit_way] = nst;
			end
			sats_pkg::REQ_TOUCH: begin
				if (hit) row_nxt.order = sats_pkg::make_mru(row_cur.order, hit_way);
			end
			sats_pkg::REQ_INSERT: begin
				if (hit) begin
					row_nxt.states[hit_way] = nst;
					row_nxt.order = sats_pkg::make_mru(row_cur.order, hit_way);
				end else begin
					// evict the LRU way
					row_nxt.tags[victim]   = req_s1.tag[sats_pkg::TAG_BITS-1:0];
					row_nxt.states[victim] = nst;
					row_nxt.order = sats_pkg::make_mru(row_cur.order, victim);
				end
			end
			default: begin
			end
		endcase
	end

	// ways present in the new LRU order, for checking only
	always_comb begin
		ord_mask = '0;
		for (int i = 0; i < sats_pkg::WAYS; i++) begin
			ord_mask[row_nxt.order[i]] = 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			byp_vld_q <= 1'b0;
			done_q    <= 1'b0;
			row_vld_q <= '0;
		end else begin
			vld_s1    <= accept;
			byp_vld_q <= vld_s1;
			done_q    <= vld_s1;
			if (vld_s1) row_vld_q[set_s1] <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) req_s1 <= req;
		if (vld_s1) begin
			byp_set_q          <= set_s1;
			wr_row_q           <= row_nxt;
			rsp_q.line_state   <= prior_state;
			rsp_q.hit          <= hit;
			rsp_q.victim_dirty <= dirty;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("response without a request two cycles earlier");

	a_row_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((row_vld_q & $past(row_vld_q)) == $past(row_vld_q)))
		else $error("set valid bit dropped after being written");

	a_lru_permutation: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (ord_mask == '1))
		else $error("LRU order is not a permutation of the ways");

	a_miss_is_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> (rsp.line_state == sats_pkg::ST_INVALID))
		else $error("miss reported with a non-invalid state");
`endif

endmodule
